// ===== sv/jsu_pkg.sv =====
package jsu_pkg;

	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_STR  = 3'd1;
	localparam logic [2:0] MODE_ESC  = 3'd2;
	localparam logic [2:0] MODE_HEX  = 3'd3;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_VALUE = 2'd1;
	localparam logic [1:0] ERR_END   = 2'd2;
	localparam logic [1:0] ERR_CODE  = 2'd3;

	localparam logic [7:0] DEL_BYTE  = 8'd127;
	localparam int         HEX_BASE  = 16;
	localparam int         HEX_BITS  = $clog2(HEX_BASE);
	localparam logic [3:0] HEX_ALPHA = 4'd10;

	localparam int GRP_SLOTS = 3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [1:0] error_code;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t [GRP_SLOTS-1:0] r;
	} res_grp_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= "0" && c <= "9") begin
			h.val = 4'(c - "0");
		end else if (c >= "A" && c <= "F") begin
			h.val = 4'(c - "A") + HEX_ALPHA;
		end else if (c >= "a" && c <= "f") begin
			h.val = 4'(c - "a") + HEX_ALPHA;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] b,
		input logic [1:0] err);
		res_t r;
		r.kind       = kind;
		r.out_byte   = b;
		r.error_code = err;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

// ===== sv/jsu_ifs.sv =====
interface jsu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_end;

	modport source (output valid, output data_byte, output stream_end, input ready);
	modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

interface jsu_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [1:0] error_code;
	logic       last;

	modport source (output valid, output kind, output out_byte, output error_code,
		output last, input ready);
	modport sink (input valid, input kind, input out_byte, input error_code,
		input last, output ready);
endinterface

// ===== sv/jsu_decode.sv =====
module jsu_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data_byte,
	input  logic               stream_end,
	output jsu_pkg::res_grp_t  grp
);

	logic [2:0]  mode_q, mode_d;
	logic [1:0]  hex_count_q, hex_count_d;
	logic [15:0] code_accum_q, code_accum_d;

	jsu_pkg::hex_t h;
	logic [15:0]   cp;
	logic [7:0]    esc_byte;
	logic          esc_ok;

	assign h  = jsu_pkg::hex_value(data_byte);
	assign cp = {code_accum_q[15-jsu_pkg::HEX_BITS:0], h.val};

	always_comb begin
		esc_ok   = 1'b1;
		esc_byte = data_byte;
		case (data_byte)
			8'h22, 8'h5C, 8'h2F: esc_byte = data_byte;
			"b": esc_byte = 8'h08;
			"f": esc_byte = 8'h0C;
			"n": esc_byte = 8'h0A;
			"r": esc_byte = 8'h0D;
			"t": esc_byte = 8'h09;
			default: esc_ok = 1'b0;
		endcase
	end

	always_comb begin
		mode_d       = mode_q;
		hex_count_d  = hex_count_q;
		code_accum_d = code_accum_q;
		grp.cnt      = 2'd0;
		for (int i = 0; i < jsu_pkg::GRP_SLOTS; i++) begin
			grp.r[i] = '0;
		end

		if (stream_end) begin
			mode_d       = jsu_pkg::MODE_IDLE;
			hex_count_d  = 2'd0;
			code_accum_d = 16'd0;
			grp.cnt      = 2'd1;
			grp.r[0]     = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'd0, jsu_pkg::ERR_END);
		end else begin
			case (mode_q)
				jsu_pkg::MODE_STR: begin
					if (data_byte == 8'h22) begin
						mode_d   = jsu_pkg::MODE_IDLE;
						grp.cnt  = 2'd1;
						grp.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DONE, 8'd0, jsu_pkg::ERR_NONE);
					end else if (data_byte == 8'h5C) begin
						mode_d = jsu_pkg::MODE_ESC;
					end else if (data_byte >= 8'h20 && data_byte != jsu_pkg::DEL_BYTE) begin
						grp.cnt  = 2'd1;
						grp.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, data_byte,
							jsu_pkg::ERR_NONE);
					end else begin
						mode_d       = jsu_pkg::MODE_IDLE;
						hex_count_d  = 2'd0;
						code_accum_d = 16'd0;
						grp.cnt      = 2'd1;
						grp.r[0]     = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'd0,
							jsu_pkg::ERR_VALUE);
					end
				end
				jsu_pkg::MODE_ESC: begin
					if (data_byte == "u") begin
						mode_d       = jsu_pkg::MODE_HEX;
						hex_count_d  = 2'd0;
						code_accum_d = 16'd0;
					end else if (esc_ok) begin
						mode_d   = jsu_pkg::MODE_STR;
						grp.cnt  = 2'd1;
						grp.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, esc_byte,
							jsu_pkg::ERR_NONE);
					end else begin
						mode_d       = jsu_pkg::MODE_IDLE;
						hex_count_d  = 2'd0;
						code_accum_d = 16'd0;
						grp.cnt      = 2'd1;
						grp.r[0]     = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'd0,
							jsu_pkg::ERR_VALUE);
					end
				end
				jsu_pkg::MODE_HEX: begin
					if (!h.ok) begin
						mode_d       = jsu_pkg::MODE_IDLE;
						hex_count_d  = 2'd0;
						code_accum_d = 16'd0;
						grp.cnt      = 2'd1;
						grp.r[0]     = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'd0,
							jsu_pkg::ERR_VALUE);
					end else if (hex_count_q != 2'd3) begin
						code_accum_d = cp;
						hex_count_d  = hex_count_q + 2'd1;
					end else begin
						hex_count_d  = 2'd0;
						code_accum_d = 16'd0;
						if (cp >= 16'hD800 && cp <= 16'hDFFF) begin
							mode_d   = jsu_pkg::MODE_IDLE;
							grp.cnt  = 2'd1;
							grp.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'd0,
								jsu_pkg::ERR_CODE);
						end else begin
							mode_d = jsu_pkg::MODE_STR;
							if (cp < 16'h0080) begin
								grp.cnt  = 2'd1;
								grp.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, cp[7:0],
									jsu_pkg::ERR_NONE);
							end else if (cp < 16'h0800) begin
								grp.cnt  = 2'd2;
								grp.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA,
									{3'b110, cp[10:6]}, jsu_pkg::ERR_NONE);
								grp.r[1] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA,
									{2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
							end else begin
								grp.cnt  = 2'd3;
								grp.r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA,
									{4'b1110, cp[15:12]}, jsu_pkg::ERR_NONE);
								grp.r[1] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA,
									{2'b10, cp[11:6]}, jsu_pkg::ERR_NONE);
								grp.r[2] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA,
									{2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
							end
						end
					end
				end
				default: begin
					// idle, and any unused mode code behaves as idle
					mode_d = jsu_pkg::MODE_IDLE;
					if (data_byte == 8'h20 || data_byte == 8'h09 ||
						data_byte == 8'h0D || data_byte == 8'h0A) begin
						mode_d = jsu_pkg::MODE_IDLE;
					end else if (data_byte == 8'h22) begin
						mode_d = jsu_pkg::MODE_STR;
					end else begin
						hex_count_d  = 2'd0;
						code_accum_d = 16'd0;
						grp.cnt      = 2'd1;
						grp.r[0]     = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'd0,
							jsu_pkg::ERR_VALUE);
					end
				end
			endcase
		end

		// mark the final result of the word
		for (int i = 0; i < jsu_pkg::GRP_SLOTS; i++) begin
			grp.r[i].last = (grp.cnt == 2'(i + 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= jsu_pkg::MODE_IDLE;
			hex_count_q  <= 2'd0;
			code_accum_q <= 16'd0;
		end else if (step) begin
			mode_q       <= mode_d;
			hex_count_q  <= hex_count_d;
			code_accum_q <= code_accum_d;
		end
	end

endmodule

// ===== sv/jsu_result_buf.sv =====
module jsu_result_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  jsu_pkg::res_grp_t grp,
	output logic              free,
	jsu_res_if.source         result
);

	jsu_pkg::res_grp_t grp_q;
	logic              grp_valid_q;
	logic [1:0]        idx_q;
	logic              at_last;
	jsu_pkg::res_t     cur;

	assign at_last = (idx_q == grp_q.cnt - 2'd1);
	assign free    = !grp_valid_q || (result.ready && at_last);

	always_comb begin
		case (idx_q)
			2'd0:    cur = grp_q.r[0];
			2'd1:    cur = grp_q.r[1];
			default: cur = grp_q.r[2];
		endcase
	end

	assign result.valid      = grp_valid_q;
	assign result.kind       = cur.kind;
	assign result.out_byte   = cur.out_byte;
	assign result.error_code = cur.error_code;
	assign result.last       = cur.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (load) begin
			grp_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (grp_valid_q && result.ready) begin
			// advance through the group, drop it after its last word
			if (at_last) begin
				grp_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= grp;
		end
	end

endmodule

// ===== sv/json_string_unescape_utf8.sv =====
// JSON string literal unescaper.
// The stream channel takes one word per cycle: a raw byte of the literal, or an
// end marker (stream_end) that closes the stream. The result channel gives one
// word per decoded byte, a word for a completed string, or an error word; last
// marks the final word caused by one input word.
// A word is registered at the input and, once the result register is free,
// decoded into the result register, where its first result, if any, is valid.
// Throughput: one input word per cycle while each word causes at most one
// result and result.ready is high. A \uXXXX escape that expands to two or three
// UTF-8 bytes holds the result register until its last byte is taken, and the
// input waits behind it; the result register is the limit on rate.
// Words that cause no result (whitespace, an opening quote, a backslash, the
// first three hex digits) load nothing, but wait while a held group blocks.
// Reset: arst_n clears the input register, the result register and the decode
// state to idle, waiting for an opening quote.
// Stall: while result.ready is low the current result is held; an empty input
// register still takes one more word, then stream.ready drops until the last
// word of the held group is taken.
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	jsu_byte_if.sink   stream,
	jsu_res_if.source  result
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              end_s1;
	logic              step;
	logic              free;
	jsu_pkg::res_grp_t grp;

	assign step         = valid_s1 && free;
	assign stream.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_s1 <= stream.data_byte;
			end_s1  <= stream.stream_end;
		end
	end

	jsu_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (data_s1),
		.stream_end (end_s1),
		.grp        (grp)
	);

	jsu_result_buf u_result_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && grp.cnt != 2'd0),
		.grp    (grp),
		.free   (free),
		.result (result)
	);

endmodule

// ===== sv/jsu_checker.sv =====
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] out_byte,
	input logic [1:0] error_code,
	input logic       last
);

	// no result survives reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// input backs up only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |-> (out_valid && !(out_ready && last)))
		else $error("input stalled without a pending result");

	// done and error words end their group and carry consistent codes
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != jsu_pkg::KIND_DATA) |->
		(last && out_byte == 8'd0 &&
		((kind == jsu_pkg::KIND_ERR) == (error_code != jsu_pkg::ERR_NONE))))
		else $error("bad terminating result word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(kind) && $stable(out_byte) && $stable(error_code)
		&& $stable(last)))
		else $error("stalled result changed");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (stream.valid),
	.in_ready   (stream.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.kind       (result.kind),
	.out_byte   (result.out_byte),
	.error_code (result.error_code),
	.last       (result.last)
);
